[rtl/core/viscoelastic_maxwell_stress_update_top_assert.svh]
// Assertion macros for the viscoelastic stress update block.
// Expects signals named clk and rst in the including module's scope.
`ifndef VISCOELASTIC_MAXWELL_STRESS_UPDATE_TOP_ASSERT_SVH
`define VISCOELASTIC_MAXWELL_STRESS_UPDATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VMSU_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vmsu check failed");
`define VMSU_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("vmsu check failed");
`else
`define VMSU_ASSERT(name, prop)
`define VMSU_ASSERT_ALWAYS(name, prop)
`endif
`endif

[rtl/core/vmsu_pkg.sv]
// Shared types, constants and width helpers for the Maxwell stress update.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vmsu_pkg;

  localparam int NUM_COMP   = 6;
  localparam int NUM_NORMAL = 3;
  localparam int STRAIN_W   = 32;
  localparam int STRESS_W   = 48;
  localparam int COEF_W     = 31;
  localparam int DECAY_W    = COEF_W + 1;  // reset value 2^FRAC_BITS may need bit 31
  localparam int OPA_W      = 33;          // narrow multiplier operand, signed
  localparam int DIGIT_W    = 24;          // bits of the wide operand per step
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = NUM_COMP * STRAIN_W;
  localparam int OUT_DATA_W = NUM_COMP * STRESS_W;
  localparam int IN_USER_W  = 2;
  localparam int USER_KIND  = 0;
  localparam int USER_STORE = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MU     = 8'd3;

  typedef enum logic [2:0] {
    OP_DF,    // decay * (one + coef), rounded
    OP_AUX1,  // strain * (one - coef), rounded
    OP_AUX2,  // minus prev_strain * df, rounded
    OP_DEC,   // prev_stress * decay, rounded
    OP_LAM,   // plus lambda * trace, exact
    OP_MU     // plus (2)mu * aux, exact
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_TRACE,
    ST_SAT,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_MUL,
    PH_RND,
    PH_WB
  } phase_t;

  typedef struct packed {
    logic load;    // take the strain of an accepted word
    logic mul;     // one digit step of the multiplier
    logic first;   // first digit of an operation
    logic rnd;     // round or pass the product
    logic wb;      // write the result into its destination
    op_t  op;
    logic sat;     // clamp the accumulator into the result
    logic upd;     // retire the word: state update
    logic commit;
    logic keep;
  } lane_cmd_t;

  function automatic int df_w(int f);
    return 63 - f;
  endfunction

  function automatic int aux_w(int f);
    int a;
    int b;
    a = 65 - f;
    b = 96 - 2 * f;
    return ((a > b) ? a : b) + 2;
  endfunction

  function automatic int tr_w(int f);
    return aux_w(f) + 2;
  endfunction

  function automatic int num_digits(int f);
    int bw;
    bw = STRESS_W;
    if (df_w(f) + 1 > bw) bw = df_w(f) + 1;
    if (tr_w(f) > bw) bw = tr_w(f);
    if (OPA_W + 1 > bw) bw = OPA_W + 1;
    return (bw + DIGIT_W - 1) / DIGIT_W;
  endfunction

  function automatic op_t next_op(op_t op);
    op_t r;
    case (op)
      OP_DF:   r = OP_AUX1;
      OP_AUX1: r = OP_AUX2;
      OP_AUX2: r = OP_DEC;
      OP_DEC:  r = OP_LAM;
      OP_LAM:  r = OP_MU;
      default: r = OP_DF;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/viscoelastic_maxwell_stress_update_top.sv]
// Top level of the one-branch Maxwell viscoelastic stress update.
// Depends on vmsu_pkg, vmsu_lane, vmsu_merge and the assertion macro header.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready  | tdata: six strains, tuser: kind, store
//  m_axis   | out       | m_axis_tvalid/tready  | tdata: six saturated stresses
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Six lanes, one per Voigt component, run in lockstep. Each lane has one 33 x 25
// bit multiplier that takes its wide operand 24 bits a cycle; an operation runs
// ND digit steps, a round and a write back; ND is 2 at FRAC_BITS = 30. An evaluate
// word runs six operations, a trace load and a saturate step; a commit word goes
// straight to the final state. No new word is taken until the last is retired.
// Reset is synchronous: configuration registers return to decay = one, all else
// zero, and the stored strain and stress history is cleared. A full output
// register holds the block in its final state until the result word is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "viscoelastic_maxwell_stress_update_top_assert.svh"

module viscoelastic_maxwell_stress_update_top
  import vmsu_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // strain_xx, strain_yy, strain_zz, strain_xy, strain_yz, strain_xz (32 bits each)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind, store_trial
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz (48 bits each)
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AUX_W = aux_w(FRAC_BITS);
  localparam int TR_W  = tr_w(FRAC_BITS);
  localparam int ND    = num_digits(FRAC_BITS);
  localparam int DC_W  = $clog2(ND);
  localparam logic [DC_W-1:0] DC_LAST = DC_W'(ND - 1);
  localparam logic [DECAY_W-1:0] ONE_D = {{(DECAY_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  // configuration registers
  logic [DECAY_W-1:0]           decay;
  logic [COEF_W-1:0]            coef;
  logic signed [CFG_DATA_W-1:0] lambda;
  logic [COEF_W-1:0]            mu;

  // operands derived from configuration
  logic [OPA_W-1:0]             one_plus;
  logic signed [OPA_W-1:0]      one_minus;
  logic signed [OPA_W-1:0]      decay_a;
  logic signed [OPA_W-1:0]      lam_a [NUM_COMP];
  logic signed [OPA_W-1:0]      mu_a  [NUM_COMP];

  ctrl_state_t                  state;
  ctrl_state_t                  state_next;
  op_t                          op;
  phase_t                       phase;
  logic [DC_W-1:0]              dcnt;
  logic                         item_commit;
  logic                         item_keep;
  logic                         in_fire;
  logic                         out_free;
  logic                         trace_load;
  lane_cmd_t                    lane_cmd;

  logic signed [AUX_W-1:0]      lane_aux [NUM_COMP];
  logic signed [AUX_W-1:0]      norm_aux [NUM_NORMAL];
  logic signed [STRESS_W-1:0]   lane_res [NUM_COMP];
  logic signed [TR_W-1:0]       trace;
  logic [OUT_DATA_W-1:0]        out_data;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  // configuration writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      decay  <= ONE_D;
      coef   <= '0;
      lambda <= '0;
      mu     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DECAY:  decay  <= DECAY_W'(cfg_data[COEF_W-1:0]);
        CFG_COEF:   coef   <= cfg_data[COEF_W-1:0];
        CFG_LAMBDA: lambda <= $signed(cfg_data);
        CFG_MU:     mu     <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // one + coef and one - coef, both exact in 33 bits
  always_comb begin
    one_plus  = OPA_W'(ONE_D) + OPA_W'(coef);
    one_minus = $signed(OPA_W'(ONE_D) - OPA_W'(coef));
  end

  assign decay_a = $signed(OPA_W'(decay));

  // normals see lambda and 2*mu, shears see no lambda and plain mu
  for (genvar g = 0; g < NUM_COMP; g++) begin : g_coef
    if (g < NUM_NORMAL) begin : g_normal
      assign lam_a[g] = OPA_W'(lambda);
      assign mu_a[g]  = $signed(OPA_W'({mu, 1'b0}));
    end else begin : g_shear
      assign lam_a[g] = '0;
      assign mu_a[g]  = $signed(OPA_W'(mu));
    end
  end

  // hold the word's control bits for the whole evaluation
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_commit <= s_axis_tuser[USER_KIND];
      item_keep   <= s_axis_tuser[USER_STORE];
    end
  end

  // operation and phase sequencing inside the calculate state
  always_ff @(posedge clk) begin
    if (rst || in_fire) begin
      op    <= OP_DF;
      phase <= PH_MUL;
      dcnt  <= '0;
    end else if (state == ST_CALC) begin
      case (phase)
        PH_MUL: begin
          if (dcnt == DC_LAST) begin
            phase <= PH_RND;
            dcnt  <= '0;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        PH_RND: phase <= PH_WB;
        PH_WB: begin
          phase <= PH_MUL;
          op    <= next_op(op);
        end
        default: phase <= PH_MUL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = s_axis_tuser[USER_KIND] ? ST_DONE : ST_CALC;
        end
      end
      ST_CALC: begin
        if (phase == PH_WB && op == OP_AUX2) begin
          state_next = ST_TRACE;
        end else if (phase == PH_WB && op == OP_MU) begin
          state_next = ST_SAT;
        end
      end
      ST_TRACE: state_next = ST_CALC;
      ST_SAT:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    lane_cmd        = '0;
    lane_cmd.op     = op;
    lane_cmd.commit = item_commit;
    lane_cmd.keep   = item_keep;
    lane_cmd.load   = in_fire;
    s_axis_tready   = 1'b0;
    trace_load      = 1'b0;
    unique case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_CALC: begin
        lane_cmd.mul   = (phase == PH_MUL);
        lane_cmd.first = (phase == PH_MUL) && (dcnt == '0);
        lane_cmd.rnd   = (phase == PH_RND);
        lane_cmd.wb    = (phase == PH_WB);
      end
      ST_TRACE: trace_load   = 1'b1;
      ST_SAT:   lane_cmd.sat = 1'b1;
      ST_DONE:  lane_cmd.upd = out_free;
      default: ;
    endcase
  end

  for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
    vmsu_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .cmd       (lane_cmd),
      .strain_in ($signed(s_axis_tdata[g*STRAIN_W +: STRAIN_W])),
      .decay_a   (decay_a),
      .one_minus (one_minus),
      .one_plus  (one_plus),
      .lam_a     (lam_a[g]),
      .mu_a      (mu_a[g]),
      .trace     (trace),
      .aux       (lane_aux[g]),
      .result    (lane_res[g])
    );
  end

  for (genvar g = 0; g < NUM_NORMAL; g++) begin : g_norm
    assign norm_aux[g] = lane_aux[g];
  end

  vmsu_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk   (clk),
    .load  (trace_load),
    .aux_n (norm_aux),
    .trace (trace)
  );

  // output register: advance on retire, drop valid once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (lane_cmd.upd) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_cmd.upd) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        out_data[i*STRESS_W +: STRESS_W] <= lane_res[i];
      end
    end
  end

  assign m_axis_tdata = out_data;

  `VMSU_ASSERT(a_busy_after_accept, in_fire |=> (state != ST_IDLE))
  `VMSU_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
  `VMSU_ASSERT(a_wb_after_rnd, lane_cmd.rnd |=> lane_cmd.wb)
  `VMSU_ASSERT(a_eval_not_retired_early, (in_fire && !s_axis_tuser[USER_KIND]) |=> !lane_cmd.upd)
  `VMSU_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (state == ST_IDLE) && !m_axis_tvalid)

endmodule

`default_nettype wire

[rtl/core/vmsu_lane.sv]
// One Voigt component of the stress update: digit-serial multiplier,
// rounding, accumulation, saturation and the component's stored state. Uses vmsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmsu_lane
  import vmsu_pkg::*;
#(
  parameter int FRAC_BITS = 30,
  localparam int AUX_W = aux_w(FRAC_BITS),
  localparam int TR_W  = tr_w(FRAC_BITS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_cmd_t                  cmd,
  input  logic signed [STRAIN_W-1:0] strain_in,
  input  logic signed [OPA_W-1:0]    decay_a,
  input  logic signed [OPA_W-1:0]    one_minus,
  input  logic [OPA_W-1:0]           one_plus,
  input  logic signed [OPA_W-1:0]    lam_a,
  input  logic signed [OPA_W-1:0]    mu_a,
  input  logic signed [TR_W-1:0]     trace,
  output logic signed [AUX_W-1:0]    aux,
  output logic signed [STRESS_W-1:0] result
);

  localparam int DF_W  = df_w(FRAC_BITS);
  localparam int ND    = num_digits(FRAC_BITS);
  localparam int NDW   = ND * DIGIT_W;
  localparam int PW    = OPA_W + NDW;
  localparam int ACC_W = PW + 2;
  localparam int TERM_W = OPA_W + DIGIT_W + 1;
  localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [STRESS_W-1:0] SAT_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
  localparam logic [STRESS_W-1:0] SAT_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

  logic signed [STRAIN_W-1:0] strain;
  logic signed [STRAIN_W-1:0] prev_strain;
  logic signed [STRAIN_W-1:0] trial_strain;
  logic signed [STRESS_W-1:0] prev_stress;
  logic signed [STRESS_W-1:0] trial_stress;
  logic signed [STRESS_W-1:0] res;
  logic [DF_W-1:0]            df;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       prod_next;
  logic signed [PW-1:0]       rnd;
  logic [NDW-1:0]             breg;
  logic [NDW-1:0]             bsrc;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [NDW-1:0]      b_ext;
  logic signed [DIGIT_W:0]    dig_s;
  logic signed [TERM_W-1:0]   term;
  logic                       rounds;

  // operand selection per operation
  always_comb begin
    case (cmd.op) inside
      OP_DF, OP_DEC: op_a = decay_a;
      OP_AUX1:       op_a = one_minus;
      OP_AUX2:       op_a = OPA_W'(prev_strain);
      OP_LAM:        op_a = lam_a;
      OP_MU:         op_a = mu_a;
      default:       op_a = '0;
    endcase
    case (cmd.op)
      OP_DF:   b_ext = NDW'($signed({1'b0, one_plus}));
      OP_AUX1: b_ext = NDW'(strain);
      OP_AUX2: b_ext = NDW'($signed({1'b0, df}));
      OP_DEC:  b_ext = NDW'(prev_stress);
      OP_LAM:  b_ext = NDW'(trace);
      OP_MU:   b_ext = NDW'(aux);
      default: b_ext = '0;
    endcase
    rounds = !(cmd.op == OP_LAM || cmd.op == OP_MU);
  end

  // MSB-first digit step: top digit signed, the rest unsigned
  always_comb begin
    bsrc = cmd.first ? b_ext : breg;
    if (cmd.first) begin
      dig_s = {bsrc[NDW-1], bsrc[NDW-1 -: DIGIT_W]};
    end else begin
      dig_s = {1'b0, bsrc[NDW-1 -: DIGIT_W]};
    end
    term = op_a * dig_s;
    if (cmd.first) begin
      prod_next = PW'(term);
    end else begin
      prod_next = (prod <<< DIGIT_W) + PW'(term);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      strain <= strain_in;
    end
    if (cmd.mul) begin
      prod <= prod_next;
      breg <= bsrc << DIGIT_W;
    end
    if (cmd.rnd) begin
      rnd <= rounds ? ((prod + HALF) >>> FRAC_BITS) : prod;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_DF:   df  <= rnd[DF_W-1:0];
        OP_AUX1: aux <= rnd[AUX_W-1:0];
        OP_AUX2: aux <= aux - rnd[AUX_W-1:0];
        OP_DEC:  acc <= ACC_W'(rnd);
        default: acc <= acc + ACC_W'(rnd);
      endcase
    end
    if (cmd.sat) begin
      if (acc[ACC_W-1:STRESS_W-1] == '0 || acc[ACC_W-1:STRESS_W-1] == '1) begin
        res <= acc[STRESS_W-1:0];
      end else if (acc[ACC_W-1]) begin
        res <= SAT_MIN;
      end else begin
        res <= SAT_MAX;
      end
    end
  end

  // history and trial values of this component
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_strain  <= '0;
      prev_stress  <= '0;
      trial_strain <= '0;
      trial_stress <= '0;
    end else if (cmd.upd) begin
      if (cmd.commit) begin
        prev_strain <= trial_strain;
        prev_stress <= trial_stress;
      end else if (cmd.keep) begin
        trial_strain <= strain;
        trial_stress <= res;
      end
    end
  end

  assign result = cmd.commit ? trial_stress : res;

endmodule

`default_nettype wire

[rtl/core/vmsu_merge.sv]
// Merge stage: sums the normal-component aux values of the lanes into the trace.
// Uses vmsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmsu_merge
  import vmsu_pkg::*;
#(
  parameter int FRAC_BITS = 30,
  localparam int AUX_W = aux_w(FRAC_BITS),
  localparam int TR_W  = tr_w(FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [AUX_W-1:0] aux_n [NUM_NORMAL],
  output logic signed [TR_W-1:0]  trace
);

  logic signed [TR_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_NORMAL; i++) begin
      sum = sum + TR_W'(aux_n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trace <= sum;
    end
  end

endmodule

`default_nettype wire

[sim/vmsu_stress_checker.sv]
// Word-kind codes shared by the bench, and the checker that predicts and compares stress words.
// Depends on vmsu_pkg; watches the config, input and output channels of the stress update block.
`timescale 1ns / 1ps

package vmsu_tb_pkg;

  typedef enum logic {
    KIND_EVAL   = 1'b0,
    KIND_COMMIT = 1'b1
  } kind_t;

endpackage

module vmsu_stress_checker
  import vmsu_pkg::*;
  import vmsu_tb_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending_words
);

  typedef logic signed [127:0] wide_t;

  localparam wide_t ONE        = wide_t'(1) <<< FRAC_BITS;
  localparam wide_t HALF       = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam wide_t STRESS_MAX = (wide_t'(1) <<< (STRESS_W - 1)) - 1;
  localparam wide_t STRESS_MIN = -(wide_t'(1) <<< (STRESS_W - 1));

  logic        [COEF_W-1:0]     decay_r, coef_r, mu_r;
  logic signed [CFG_DATA_W-1:0] lambda_r;
  logic signed [STRAIN_W-1:0]   prev_strain [NUM_COMP];
  logic signed [STRAIN_W-1:0]   trial_strain [NUM_COMP];
  logic signed [STRESS_W-1:0]   prev_stress [NUM_COMP];
  logic signed [STRESS_W-1:0]   trial_stress [NUM_COMP];

  logic [OUT_DATA_W-1:0] stress_q [$];
  int                    fail_cnt = 0;
  string field_name [NUM_COMP] = '{"stress_xx", "stress_yy", "stress_zz",
                                   "stress_xy", "stress_yz", "stress_xz"};

  // a*b / one, rounded to nearest with ties toward plus infinity
  function automatic wide_t round_frac(input wide_t a, input wide_t b);
    return (a * b + HALF) >>> FRAC_BITS;
  endfunction

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic logic [OUT_DATA_W-1:0] update_point(input logic [IN_USER_W-1:0] user,
                                                         input logic [IN_DATA_W-1:0]  data);
    logic [OUT_DATA_W-1:0]      word;
    wide_t                      one_minus, df, tr, acc;
    wide_t                      aux [NUM_COMP];
    logic signed [STRAIN_W-1:0] strain [NUM_COMP];
    logic signed [STRESS_W-1:0] stress [NUM_COMP];
    if (user[USER_KIND] == KIND_COMMIT) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        prev_strain[i] = trial_strain[i];
        prev_stress[i] = trial_stress[i];
        stress[i]      = trial_stress[i];
      end
    end else begin
      one_minus = ONE - wide_t'(coef_r);
      df = (wide_t'(decay_r) * (ONE + wide_t'(coef_r)) + HALF) >>> FRAC_BITS;
      for (int i = 0; i < NUM_COMP; i++) begin
        strain[i] = data[i*STRAIN_W +: STRAIN_W];
        aux[i] = round_frac(strain[i], one_minus) - round_frac(prev_strain[i], df);
      end
      tr = aux[0] + aux[1] + aux[2];
      for (int i = 0; i < NUM_COMP; i++) begin
        acc = round_frac(prev_stress[i], wide_t'(decay_r));
        if (i < NUM_NORMAL) acc += wide_t'(lambda_r) * tr + 2 * wide_t'(mu_r) * aux[i];
        else acc += wide_t'(mu_r) * aux[i];
        if (acc > STRESS_MAX) acc = STRESS_MAX;
        else if (acc < STRESS_MIN) acc = STRESS_MIN;
        stress[i] = acc[STRESS_W-1:0];
      end
      if (user[USER_STORE]) begin
        for (int i = 0; i < NUM_COMP; i++) begin
          trial_strain[i] = strain[i];
          trial_stress[i] = stress[i];
        end
      end
    end
    for (int i = 0; i < NUM_COMP; i++) word[i*STRESS_W +: STRESS_W] = stress[i];
    return word;
  endfunction

  always @(posedge clk) begin : watch
    logic [OUT_DATA_W-1:0] want;
    if (rst) begin
      decay_r  = COEF_W'(1) << FRAC_BITS;
      coef_r   = '0;
      lambda_r = '0;
      mu_r     = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
        prev_strain[i]  = '0;
        trial_strain[i] = '0;
        prev_stress[i]  = '0;
        trial_stress[i] = '0;
      end
      stress_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DECAY:  decay_r  = cfg_data[COEF_W-1:0];
          CFG_COEF:   coef_r   = cfg_data[COEF_W-1:0];
          CFG_LAMBDA: lambda_r = cfg_data;
          CFG_MU:     mu_r     = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (stress_q.size() == 0) begin
          note_fail($sformatf("result word %h with nothing expected", m_axis_tdata));
        end else begin
          want = stress_q.pop_front();
          for (int i = 0; i < NUM_COMP; i++) begin
            if (m_axis_tdata[i*STRESS_W +: STRESS_W] !== want[i*STRESS_W +: STRESS_W])
              note_fail($sformatf("%s expected %0d got %0d", field_name[i],
                                  $signed(want[i*STRESS_W +: STRESS_W]),
                                  $signed(m_axis_tdata[i*STRESS_W +: STRESS_W])));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        stress_q.push_back(update_point(s_axis_tuser, s_axis_tdata));
    end
    mismatches    <= fail_cnt;
    pending_words <= stress_q.size();
  end

endmodule

[sim/viscoelastic_maxwell_stress_update_top_tb.sv]
// Stimulus and verdict for the Maxwell viscoelastic stress update block.
// Depends on vmsu_pkg, the RTL top and vmsu_stress_checker (with vmsu_tb_pkg).
`timescale 1ns / 1ps

module viscoelastic_maxwell_stress_update_top_tb;
  import vmsu_pkg::*;
  import vmsu_tb_pkg::*;

  localparam int FRAC_BITS   = 30;
  localparam int HOLD_CYCLES = 300;     // long output back-pressure stretch
  localparam int DRAIN_WAIT  = 40;      // a bit more than one evaluate word
  localparam int CYCLE_LIMIT = 400000;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;

  localparam logic [STRAIN_W-1:0]   MAX_STRAIN = 32'h7FFF_FFFF;
  localparam logic [STRAIN_W-1:0]   MIN_STRAIN = 32'h8000_0000;
  localparam logic [CFG_DATA_W-1:0] ONE_FX     = 32'h4000_0000;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending_words;
  int cycle_cnt = 0;

  bit steady     = 1'b0;  // suppress random idling on both sides
  bit stall_now  = 1'b0;  // ask the receiver for one long hold-off
  bit stall_done = 1'b0;  // receiver has run its hold-off

  viscoelastic_maxwell_stress_update_top #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  vmsu_stress_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Stop a hung run: no handshake wait may outlive the cycle budget.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: take result words with random stalls; on request, hold off for a
  // long counted stretch so the block fills its output register and stalls its input.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_now && !stall_done) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic logic [IN_USER_W-1:0] make_user(input kind_t kind, input logic store);
    logic [IN_USER_W-1:0] user;
    user             = '0;
    user[USER_KIND]  = kind;
    user[USER_STORE] = store;
    return user;
  endfunction

  // Pack six strains, xx in the lowest bits.
  function automatic logic [IN_DATA_W-1:0] strains6(input logic [STRAIN_W-1:0] xx, yy, zz,
                                                    input logic [STRAIN_W-1:0] xy, yz, xz);
    return {xz, yz, xy, zz, yy, xx};
  endfunction

  // Mostly modest strains so stresses stay in range, a quarter over the full 32-bit span.
  function automatic logic [IN_DATA_W-1:0] rand_strains();
    logic [IN_DATA_W-1:0] data;
    for (int i = 0; i < NUM_COMP; i++) begin
      if ($urandom_range(3) == 0) data[i*STRAIN_W +: STRAIN_W] = $urandom;
      else data[i*STRAIN_W +: STRAIN_W] = int'($urandom_range(2097152)) - 1048576;
    end
    return data;
  endfunction

  // Offer one word and hold it until taken. Valid stays high for a following
  // word; drop it only inside an idle gap or once the stream is drained.
  task automatic send_word(input logic [IN_USER_W-1:0] user, input logic [IN_DATA_W-1:0] data);
    if (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= user;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Write all four registers while the block is idle, with writes to unmapped
  // indexes mixed in.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] decay, coef, lambda, mu);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_DECAY, CFG_UNMAPPED_LO, CFG_COEF, CFG_LAMBDA, CFG_UNMAPPED_HI, CFG_MU};
    val = '{decay, $urandom, coef, lambda, $urandom, mu};
    wait_drained();
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random register set: mostly physical values, sometimes the extremes, with
  // junk in the unused top bit of the 31-bit registers.
  task automatic pick_regs();
    logic [CFG_DATA_W-1:0] decay, coef, lambda, mu;
    case ($urandom_range(9))
      0:       decay = '0;
      1:       decay = 32'hFFFF_FFFF;
      2:       decay = $urandom;
      default: decay = $urandom_range(1 << 30, 1 << 29);
    endcase
    case ($urandom_range(9))
      0:       coef = '0;
      1:       coef = 32'hFFFF_FFFF;
      2:       coef = ONE_FX;
      default: coef = $urandom_range(1 << 27);
    endcase
    case ($urandom_range(9))
      0:       lambda = 32'h8000_0000;
      1:       lambda = 32'h7FFF_FFFF;
      2:       lambda = $urandom;
      default: lambda = int'($urandom_range(2097152)) - 1048576;
    endcase
    case ($urandom_range(9))
      0:       mu = '0;
      1:       mu = 32'hFFFF_FFFF;
      2:       mu = $urandom;
      default: mu = $urandom_range(1 << 22);
    endcase
    decay[31] = 1'($urandom_range(1));
    coef[31]  = 1'($urandom_range(1));
    mu[31]    = 1'($urandom_range(1));
    program_regs(decay, coef, lambda, mu);
  endtask

  initial begin
    int sent;
    int n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: commit with nothing stored moves the cleared trial into
    // the history; strains and store flag on a commit are ignored.
    send_word(make_user(KIND_COMMIT, 1'b1), strains6(MAX_STRAIN, MIN_STRAIN, 1, -1, 0, 7));
    send_word(make_user(KIND_EVAL, 1'b0), strains6(MAX_STRAIN, MAX_STRAIN, MAX_STRAIN,
                                                   MAX_STRAIN, MAX_STRAIN, MAX_STRAIN));

    // Ordinary material: store a trial, overwrite it, commit, decay the history.
    program_regs(ONE_FX - 32'h0100_0000, 32'h0400_0000, 32'd1000, 32'd2000);
    send_word(make_user(KIND_EVAL, 1'b1), strains6(MAX_STRAIN, MAX_STRAIN, MAX_STRAIN,
                                                   MAX_STRAIN, MAX_STRAIN, MAX_STRAIN));
    send_word(make_user(KIND_EVAL, 1'b1), strains6(MIN_STRAIN, MIN_STRAIN, MIN_STRAIN,
                                                   MIN_STRAIN, MIN_STRAIN, MIN_STRAIN));
    send_word(make_user(KIND_COMMIT, 1'b0), '0);
    send_word(make_user(KIND_EVAL, 1'b0), '0);
    send_word(make_user(KIND_EVAL, 1'b0), strains6(-1, -1, -1, -1, -1, -1));
    // trial untouched by the two unstored evaluations above
    send_word(make_user(KIND_COMMIT, 1'b0), '1);
    send_word(make_user(KIND_EVAL, 1'b1),
              strains6(MAX_STRAIN, MIN_STRAIN, 0, 1, -1, 32'h5555_5555));
    send_word(make_user(KIND_COMMIT, 1'b1), '0);

    // Registers above one, masked top bits, one minus coef negative: saturate both ways.
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(make_user(KIND_EVAL, 1'b1), strains6(MAX_STRAIN, MAX_STRAIN, MAX_STRAIN,
                                                   MAX_STRAIN, MAX_STRAIN, MAX_STRAIN));
    send_word(make_user(KIND_EVAL, 1'b1), strains6(MIN_STRAIN, MIN_STRAIN, MIN_STRAIN,
                                                   MIN_STRAIN, MIN_STRAIN, MIN_STRAIN));
    send_word(make_user(KIND_COMMIT, 1'b0), '0);
    send_word(make_user(KIND_EVAL, 1'b1),
              strains6(MAX_STRAIN, MIN_STRAIN, MAX_STRAIN, MIN_STRAIN, 3, -3));
    send_word(make_user(KIND_COMMIT, 1'b0), '0);
    send_word(make_user(KIND_EVAL, 1'b0), '0);

    // Lower extremes: no decay, no relaxation, most negative lambda, zero shear.
    program_regs('0, '0, 32'h8000_0000, '0);
    send_word(make_user(KIND_EVAL, 1'b1), strains6(1, 2, 3, -4, 5, -6));
    send_word(make_user(KIND_EVAL, 1'b1), strains6(MAX_STRAIN, MAX_STRAIN, MAX_STRAIN,
                                                   MAX_STRAIN, MAX_STRAIN, MAX_STRAIN));
    send_word(make_user(KIND_COMMIT, 1'b0), '0);
    send_word(make_user(KIND_EVAL, 1'b0), strains6(MIN_STRAIN, MIN_STRAIN, MIN_STRAIN,
                                                   MIN_STRAIN, MIN_STRAIN, MIN_STRAIN));

    // Coef exactly one: the new strain drops out of aux.
    program_regs(ONE_FX, ONE_FX, 32'hFFFF_FFFB, 32'd7);
    send_word(make_user(KIND_EVAL, 1'b1), rand_strains());
    send_word(make_user(KIND_COMMIT, 1'b0), '0);
    send_word(make_user(KIND_EVAL, 1'b0), rand_strains());

    // Random phases, each under a fresh register set. Most traffic is integration
    // steps (trial evaluations, then a commit); the rest is stray words. Phase 2
    // runs without idling; phase 4 starts under a long output hold-off.
    for (int phase = 0; phase < 6; phase++) begin
      pick_regs();
      steady = (phase == 2);
      if (phase == 4) stall_now = 1'b1;
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(9) < 7) begin
          n = $urandom_range(3, 1);
          repeat (n) send_word(make_user(KIND_EVAL, $urandom_range(3) != 0), rand_strains());
          send_word(make_user(KIND_COMMIT, 1'($urandom_range(1))), rand_strains());
          sent += n + 1;
        end else begin
          send_word(IN_USER_W'($urandom), rand_strains());
          sent++;
        end
      end
      steady = 1'b0;
    end

    // Let the last words come back, then give any stray output time to show.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/vmsu_pkg.sv
rtl/core/vmsu_lane.sv
rtl/core/vmsu_merge.sv
rtl/core/viscoelastic_maxwell_stress_update_top.sv
sim/vmsu_stress_checker.sv
sim/viscoelastic_maxwell_stress_update_top_tb.sv
